@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the colorizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// check on every clock edge outside reset
`define DHC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("colorizer assertion failed");

// check on every clock edge, reset included
`define DHC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("colorizer assertion failed");

`else

`define DHC_ASSERT(label, prop)
`define DHC_ASSERT_ALWAYS(label, prop)

`endif

`endif

@@ src/dhc_pkg.sv @@
// ----------------------------------------------------------------------------
// dhc_pkg
// Types, constants and helpers shared by the disparity colorizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dhc_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned DIV_CELLS = 8;   // one quotient bit per cell
    localparam int unsigned SECTOR    = 60;
    localparam int unsigned MAX_RESET = 255;
    localparam logic [PIX_W-1:0] FULL = 8'hFF;

    // word handed from cell to cell of the hue divider
    typedef struct packed {
        logic [PIX_W-1:0]     part;     // partial remainder, below divisor
        logic [PIX_W-1:0]     low;      // dividend bits not yet shifted in
        logic [DIV_CELLS-1:0] quot;     // quotient bits so far
        logic [PIX_W-1:0]     divisor;  // max disparity
        logic                 zero;     // max disparity is zero: black
    } t_div_word;

    typedef enum logic [2:0] {
        REGION_RED_YELLOW,
        REGION_YELLOW_GREEN,
        REGION_GREEN_CYAN,
        REGION_CYAN_BLUE,
        REGION_BLUE_MAGENTA,
        REGION_MAGENTA_RED
    } t_hue_region;

    // floor(255 * r / 60) == floor(17 * r / 4)
    function automatic logic [PIX_W-1:0] ramp(input logic [5:0] r);
        logic [9:0] p;
        p = {r, 4'b0000} + {4'b0000, r};
        return p[9:2];
    endfunction

endpackage

`default_nettype wire

@@ src/disparity_hue_colorizer_unit.sv @@
// ----------------------------------------------------------------------------
// disparity_hue_colorizer_unit
// Maps one 8-bit disparity pixel to a blue, green, red hue color.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while o_in_ready is high: the front
// stage clamps the pixel to max_disparity and forms (max - d) * 240, eight
// cells of the hue divider each settle one quotient bit, and the color
// stage turns the hue into the color
// triple. Every stage holds its own item, so a stall at the output only
// stops the stages behind a full one. Max disparity is red, zero is blue,
// a max_disparity of zero gives black; write it only while no item is in
// flight. Reset value of max_disparity is 255.
`default_nettype none

`include "assert_macros.svh"

module disparity_hue_colorizer_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [dhc_pkg::PIX_W-1:0]  i_cfg_wr_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [dhc_pkg::PIX_W-1:0]  i_disparity,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [dhc_pkg::PIX_W-1:0]       o_blue,
    output logic [dhc_pkg::PIX_W-1:0]       o_green,
    output logic [dhc_pkg::PIX_W-1:0]       o_red
);

    localparam int unsigned N = dhc_pkg::DIV_CELLS;

    logic [dhc_pkg::PIX_W-1:0] r_max_disparity;
    logic [N:0]                chain_valid;
    logic [N:0]                chain_ready;
    dhc_pkg::t_div_word        chain_word [N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_disparity <= dhc_pkg::PIX_W'(dhc_pkg::MAX_RESET);
        end else if (i_cfg_wr_en) begin
            r_max_disparity <= i_cfg_wr_data;
        end
    end

    dhc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max       (r_max_disparity),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_disparity (i_disparity),
        .o_valid     (chain_valid[0]),
        .i_ready     (chain_ready[0]),
        .o_word      (chain_word[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cell
        dhc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_word  (chain_word[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_word  (chain_word[k+1])
        );
    end

    dhc_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[N]),
        .o_ready (chain_ready[N]),
        .i_word  (chain_word[N]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_blue  (o_blue),
        .o_green (o_green),
        .o_red   (o_red)
    );

    // an empty output stage lets the whole chain advance
    `DHC_ASSERT(a_ready_when_drained, !o_out_valid |-> o_in_ready)

    // a fully saturated hue: one channel at full scale unless black
    `DHC_ASSERT(a_one_full_channel, o_out_valid |-> (o_blue == dhc_pkg::FULL || o_green == dhc_pkg::FULL || o_red == dhc_pkg::FULL || (o_blue == '0 && o_green == '0 && o_red == '0)))

    // a fully saturated hue: one channel always off
    `DHC_ASSERT(a_one_dark_channel, o_out_valid |-> (o_blue == '0 || o_green == '0 || o_red == '0))

    // nothing leaves the unit right after reset
    `DHC_ASSERT_ALWAYS(a_empty_after_reset, !$past(i_rst_n) |-> !o_out_valid)

endmodule

`default_nettype wire

@@ src/dhc_front.sv @@
// ----------------------------------------------------------------------------
// dhc_front
// Clamps the pixel, forms (max - d) * 240 and loads the divider word.
// ----------------------------------------------------------------------------
`default_nettype none

module dhc_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [dhc_pkg::PIX_W-1:0]  i_max,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [dhc_pkg::PIX_W-1:0]  i_disparity,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output dhc_pkg::t_div_word              o_word
);

    logic                      r_valid;
    dhc_pkg::t_div_word        r_word;
    dhc_pkg::t_div_word        n_word;
    logic [dhc_pkg::PIX_W-1:0] clamped;
    logic [dhc_pkg::PIX_W-1:0] span;
    logic [15:0]               dividend;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        clamped  = (i_disparity > i_max) ? i_max : i_disparity;
        span     = i_max - clamped;
        // span * 240 = span * 256 - span * 16
        dividend = {span, 8'h00} - {4'h0, span, 4'h0};
        n_word.part    = dividend[15:8];
        n_word.low     = dividend[7:0];
        n_word.quot    = '0;
        n_word.divisor = i_max;
        n_word.zero    = (i_max == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

@@ src/dhc_div_cell.sv @@
// ----------------------------------------------------------------------------
// dhc_div_cell
// One restoring-division cell: shifts in a dividend bit, decides one
// quotient bit and registers the word for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module dhc_div_cell (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire dhc_pkg::t_div_word i_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output dhc_pkg::t_div_word o_word
);

    logic                      r_valid;
    dhc_pkg::t_div_word        r_word;
    dhc_pkg::t_div_word        n_word;
    logic [dhc_pkg::PIX_W:0]   trial;
    logic [dhc_pkg::PIX_W:0]   diff;
    logic                      take;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        trial  = {i_word.part, i_word.low[dhc_pkg::PIX_W-1]};
        diff   = trial - {1'b0, i_word.divisor};
        take   = (trial >= {1'b0, i_word.divisor});
        n_word = i_word;
        n_word.part = take ? diff[dhc_pkg::PIX_W-1:0] : trial[dhc_pkg::PIX_W-1:0];
        n_word.low  = {i_word.low[dhc_pkg::PIX_W-2:0], 1'b0};
        n_word.quot = {i_word.quot[dhc_pkg::DIV_CELLS-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

@@ src/dhc_color.sv @@
// ----------------------------------------------------------------------------
// dhc_color
// Splits the hue into sector and offset, builds the ramps and registers
// the blue, green, red triple.
// ----------------------------------------------------------------------------
`default_nettype none

module dhc_color (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire dhc_pkg::t_div_word         i_word,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [dhc_pkg::PIX_W-1:0]       o_blue,
    output logic [dhc_pkg::PIX_W-1:0]       o_green,
    output logic [dhc_pkg::PIX_W-1:0]       o_red
);

    localparam logic [7:0] S1 = 8'(dhc_pkg::SECTOR);
    localparam logic [7:0] S2 = 8'(2 * dhc_pkg::SECTOR);
    localparam logic [7:0] S3 = 8'(3 * dhc_pkg::SECTOR);
    localparam logic [7:0] S4 = 8'(4 * dhc_pkg::SECTOR);

    logic                      r_valid;
    logic [dhc_pkg::PIX_W-1:0] r_blue, r_green, r_red;
    logic [dhc_pkg::PIX_W-1:0] n_blue, n_green, n_red;
    logic [7:0]                hue;
    logic [7:0]                offset;
    logic [5:0]                rem;
    logic [dhc_pkg::PIX_W-1:0] rise, fall;
    dhc_pkg::t_hue_region      region;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        hue = i_word.quot;
        if (hue >= S4) begin
            region = dhc_pkg::REGION_BLUE_MAGENTA;
            offset = hue - S4;
        end else if (hue >= S3) begin
            region = dhc_pkg::REGION_CYAN_BLUE;
            offset = hue - S3;
        end else if (hue >= S2) begin
            region = dhc_pkg::REGION_GREEN_CYAN;
            offset = hue - S2;
        end else if (hue >= S1) begin
            region = dhc_pkg::REGION_YELLOW_GREEN;
            offset = hue - S1;
        end else begin
            region = dhc_pkg::REGION_RED_YELLOW;
            offset = hue;
        end
        rem  = offset[5:0];
        rise = dhc_pkg::ramp(rem);
        fall = dhc_pkg::ramp(6'(dhc_pkg::SECTOR) - rem);

        case (region)
            dhc_pkg::REGION_RED_YELLOW: begin
                n_blue = '0;   n_green = rise;         n_red = dhc_pkg::FULL;
            end
            dhc_pkg::REGION_YELLOW_GREEN: begin
                n_blue = '0;   n_green = dhc_pkg::FULL; n_red = fall;
            end
            dhc_pkg::REGION_GREEN_CYAN: begin
                n_blue = rise; n_green = dhc_pkg::FULL; n_red = '0;
            end
            dhc_pkg::REGION_CYAN_BLUE: begin
                n_blue = dhc_pkg::FULL; n_green = fall; n_red = '0;
            end
            dhc_pkg::REGION_BLUE_MAGENTA: begin
                n_blue = dhc_pkg::FULL; n_green = '0;   n_red = rise;
            end
            default: begin
                n_blue = rise; n_green = '0; n_red = dhc_pkg::FULL;
            end
        endcase

        // zero maximum: black
        if (i_word.zero) begin
            n_blue  = '0;
            n_green = '0;
            n_red   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_blue  <= n_blue;
            r_green <= n_green;
            r_red   <= n_red;
        end
    end

    assign o_valid = r_valid;
    assign o_blue  = r_blue;
    assign o_green = r_green;
    assign o_red   = r_red;

endmodule

`default_nettype wire
